@@ sv/ppl_pkg.sv @@
// Shared types, constants and helper functions of the pure pursuit lookahead point block.
package ppl_pkg;

    localparam int CW  = 32;          // coordinate width
    localparam int FB  = 16;          // fraction bits
    localparam int RW  = CW - 1;      // radius width
    localparam int XW  = 64;          // working width of intermediates
    localparam int PW  = 2 * XW;      // full product width
    localparam int DVW = XW + FB;     // dividend width after the fraction shift
    localparam int NUDGE_I = ((3 << FB) + 500) / 1000;

    typedef logic signed [XW-1:0] t_x;
    typedef logic [PW-1:0]        t_p;

    localparam t_x LIM   = {3'b000, {(XW-3){1'b1}}};
    localparam t_x ONE   = t_x'(64'd1 << FB);
    localparam t_x NUDGE = t_x'(NUDGE_I);
    localparam t_x CMAX  = t_x'((64'd1 << (CW - 1)) - 64'd1);
    localparam t_x CMIN  = -CMAX - t_x'(1);

    typedef enum logic [4:0] {
        OP_NONE  = 5'd0,
        OP_NUDGE = 5'd1,
        OP_DIFF  = 5'd2,
        OP_SLOPE = 5'd3,
        OP_C     = 5'd4,
        OP_A     = 5'd5,
        OP_BH    = 5'd6,
        OP_CC1   = 5'd7,
        OP_CC2   = 5'd8,
        OP_P     = 5'd9,
        OP_Q     = 5'd10,
        OP_DISC  = 5'd11,
        OP_SQRT  = 5'd12,
        OP_U     = 5'd13,
        OP_V     = 5'd14,
        OP_NEXT  = 5'd15,
        OP_E0X   = 5'd16,
        OP_E0Y   = 5'd17,
        OP_E1X   = 5'd18,
        OP_E1Y   = 5'd19,
        OP_PICK  = 5'd20,
        OP_EMIT  = 5'd21
    } t_op;

    typedef struct packed {
        t_op  op;
        logic go;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic first;
        logic last;
        logic no_root;
        logic keep;
        logic k;
        logic two;
        logic out_free;
    } t_sts;

    function automatic logic [XW-1:0] f_abs(input t_x v);
        return v[XW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic t_x f_clamp(input t_x v);
        if (v > LIM) return LIM;
        if (v < -LIM) return -LIM;
        return v;
    endfunction

    function automatic logic signed [CW-1:0] f_coord(input t_x v);
        if (v > CMAX) return CMAX[CW-1:0];
        if (v < CMIN) return CMIN[CW-1:0];
        return v[CW-1:0];
    endfunction

endpackage

@@ sv/ppl_if.sv @@
// Valid/ready channels for path point items and follow point items.
interface ppl_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [ppl_pkg::CW-1:0]   point_x;
    logic signed [ppl_pkg::CW-1:0]   point_y;
    logic        [ppl_pkg::RW-1:0]   look_radius;
    logic signed [ppl_pkg::CW-1:0]   robot_x;
    logic signed [ppl_pkg::CW-1:0]   robot_y;
    logic                            first_point;
    logic                            last_point;

    modport source (output valid, point_x, point_y, look_radius, robot_x, robot_y,
                    first_point, last_point, input ready);
    modport sink   (input valid, point_x, point_y, look_radius, robot_x, robot_y,
                    first_point, last_point, output ready);
endinterface

interface ppl_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [ppl_pkg::CW-1:0]   follow_x;
    logic signed [ppl_pkg::CW-1:0]   follow_y;

    modport source (output valid, follow_x, follow_y, input ready);
    modport sink   (input valid, follow_x, follow_y, output ready);
endinterface

@@ sv/ppl_mul.sv @@
// Sequential 64x64 magnitude multiplier built from four registered 32x32 partial products.
module ppl_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  ppl_pkg::t_x    i_a,
    input  ppl_pkg::t_x    i_b,
    output ppl_pkg::t_p    o_prod,
    output logic           o_neg,
    output logic           o_done
);
    import ppl_pkg::*;

    localparam int HW = XW / 2;

    logic [XW-1:0] r_a, r_b, r_pp;
    logic          r_neg, r_busy, r_ppv, r_done;
    logic [2:0]    r_cnt;
    logic [1:0]    r_psel;
    t_p            r_acc;

    logic [1:0]    w_sel;
    logic [HW-1:0] w_pa, w_pb;
    t_p            w_add;

    always_comb begin
        w_sel = r_cnt[1:0];
        w_pa  = w_sel[1] ? r_a[XW-1:HW] : r_a[HW-1:0];
        w_pb  = w_sel[0] ? r_b[XW-1:HW] : r_b[HW-1:0];
        case (r_psel)
            2'd0:    w_add = PW'(r_pp);
            2'd3:    w_add = PW'(r_pp) << XW;
            default: w_add = PW'(r_pp) << HW;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_a    <= f_abs(i_a);
                r_b    <= f_abs(i_b);
                r_neg  <= i_a[XW-1] ^ i_b[XW-1];
                r_cnt  <= 3'd0;
                r_busy <= 1'b1;
                r_ppv  <= 1'b0;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt < 3'd4) begin
                    r_pp   <= XW'(w_pa) * XW'(w_pb);
                    r_psel <= w_sel;
                    r_ppv  <= 1'b1;
                    r_cnt  <= r_cnt + 3'd1;
                end else begin
                    r_ppv <= 1'b0;
                end
                if (r_ppv) begin
                    r_acc <= r_acc + w_add;
                    if (r_psel == 2'd3) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_prod = r_acc;
    assign o_neg  = r_neg;
    assign o_done = r_done;

endmodule

@@ sv/ppl_div.sv @@
// Restoring divider, one quotient bit per cycle, for (num << FB) / den with saturation.
module ppl_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  ppl_pkg::t_x    i_num,
    input  ppl_pkg::t_x    i_den,
    input  ppl_pkg::t_x    i_lim,
    output ppl_pkg::t_x    o_q,
    output logic           o_done
);
    import ppl_pkg::*;

    localparam int CNTW = $clog2(DVW + 1);

    logic [DVW-1:0]  r_sh, r_q;
    logic [XW-1:0]   r_rem, r_d, r_lim;
    logic            r_neg, r_nneg, r_zero, r_busy, r_done;
    logic [CNTW-1:0] r_cnt;

    logic [XW:0]     w_rs, w_rn;
    logic            w_ge, w_sat, w_sgn;
    logic [XW-1:0]   w_mag;

    always_comb begin
        w_rs  = {r_rem, r_sh[DVW-1]};
        w_ge  = w_rs >= {1'b0, r_d};
        w_rn  = w_rs - {1'b0, r_d};
        w_sat = (|r_q[DVW-1:XW]) || (r_q[XW-1:0] > r_lim);
        // zero divisor returns the limit with the numerator's sign
        w_mag = (r_zero || w_sat) ? r_lim : r_q[XW-1:0];
        w_sgn = r_zero ? r_nneg : r_neg;
        o_q   = w_sgn ? -t_x'(w_mag) : t_x'(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_sh   <= {f_abs(i_num), {FB{1'b0}}};
                r_d    <= f_abs(i_den);
                r_lim  <= i_lim;
                r_neg  <= i_num[XW-1] ^ i_den[XW-1];
                r_nneg <= i_num[XW-1];
                r_zero <= (i_den == '0);
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= CNTW'(DVW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_rn[XW-1:0] : w_rs[XW-1:0];
                r_q   <= {r_q[DVW-2:0], w_ge};
                r_sh  <= r_sh << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;

endmodule

@@ sv/ppl_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module ppl_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  ppl_pkg::t_p    i_d,
    output ppl_pkg::t_x    o_s,
    output logic           o_done
);
    import ppl_pkg::*;

    localparam int SN   = XW - 1;        // root bits
    localparam int RMW  = XW + 2;        // remainder width
    localparam int RSW  = RMW + 2;
    localparam int CNTW = $clog2(SN + 1);

    t_p              r_d;
    logic [RMW-1:0]  r_rem;
    logic [SN-1:0]   r_root;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy, r_done;

    logic [RSW-1:0]  w_rs, w_tr, w_df;
    logic            w_ge;

    always_comb begin
        w_rs = {r_rem, r_d[PW-1:PW-2]};
        w_tr = {{(RSW-SN-2){1'b0}}, r_root, 2'b01};
        w_ge = w_rs >= w_tr;
        w_df = w_rs - w_tr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                // discriminant stays below 2^126, so the top bit pair is dropped
                r_d    <= i_d << 2;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNTW'(SN);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_df[RMW-1:0] : w_rs[RMW-1:0];
                r_root <= {r_root[SN-2:0], w_ge};
                r_d    <= r_d << 2;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_s    = t_x'({1'b0, r_root});
    assign o_done = r_done;

endmodule

@@ sv/ppl_dp.sv @@
// Datapath: path state, segment working registers, shared arithmetic units, output register.
module ppl_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  ppl_pkg::t_cmd  i_cmd,
    output ppl_pkg::t_sts  o_sts,
    ppl_in_if.sink         i_pt,
    ppl_out_if.source      o_fp
);
    import ppl_pkg::*;

    logic signed [CW-1:0] r_rob_x, r_rob_y, r_prv_x, r_prv_y, r_cho_x, r_cho_y;
    logic signed [CW-1:0] r_ofx, r_ofy;
    logic [RW-1:0]        r_prv_r, r_rad;
    logic                 r_first, r_last, r_ov, r_k;
    logic [1:0]           r_n;
    t_x                   r_x1, r_y1, r_x2, r_y2, r_dx, r_dy, r_ux, r_vy;
    t_x                   r_m, r_c, r_a, r_bh, r_tmp, r_cc, r_s, r_u;
    t_x                   r_rx [2];
    t_x                   r_ry [2];
    t_p                   r_p, r_q, r_d;

    t_x   w_rbx, w_rby, w_ma, w_mb, w_dn, w_dd, w_dl, w_q, w_s, w_mq, w_xr;
    t_x   w_minx, w_maxx, w_nx, w_ny;
    t_p   w_prod, w_sh;
    logic w_neg, w_mdone, w_ddone, w_sdone, w_done, w_mgo, w_dgo, w_sgo;
    logic w_free, w_keep, w_sat, w_sel;
    logic [XW-1:0] w_mag;

    assign w_rbx = t_x'(r_rob_x);
    assign w_rby = t_x'(r_rob_y);

    // operand selection for the shared units
    always_comb begin
        w_ma  = '0;
        w_mb  = '0;
        w_mgo = 1'b0;
        case (i_cmd.op)
            OP_C:    begin w_ma = r_m;  w_mb = r_ux; w_mgo = i_cmd.go; end
            OP_A:    begin w_ma = r_m;  w_mb = r_m;  w_mgo = i_cmd.go; end
            OP_BH:   begin w_ma = r_m;  w_mb = r_c;  w_mgo = i_cmd.go; end
            OP_CC1:  begin w_ma = r_c;  w_mb = r_c;  w_mgo = i_cmd.go; end
            OP_CC2:  begin
                w_ma = $signed(XW'(r_rad));
                w_mb = $signed(XW'(r_rad));
                w_mgo = i_cmd.go;
            end
            OP_P:    begin w_ma = r_bh; w_mb = r_bh; w_mgo = i_cmd.go; end
            OP_Q:    begin w_ma = r_a;  w_mb = r_cc; w_mgo = i_cmd.go; end
            OP_V:    begin w_ma = r_m;  w_mb = r_u;  w_mgo = i_cmd.go; end
            OP_E0X:  begin w_ma = r_x2 - r_rx[0]; w_mb = w_ma; w_mgo = i_cmd.go; end
            OP_E0Y:  begin w_ma = r_y2 - r_ry[0]; w_mb = w_ma; w_mgo = i_cmd.go; end
            OP_E1X:  begin w_ma = r_x2 - r_rx[1]; w_mb = w_ma; w_mgo = i_cmd.go; end
            OP_E1Y:  begin w_ma = r_y2 - r_ry[1]; w_mb = w_ma; w_mgo = i_cmd.go; end
            default: begin w_ma = '0; w_mb = '0; w_mgo = 1'b0; end
        endcase
    end

    always_comb begin
        if (i_cmd.op == OP_SLOPE) begin
            w_dn = r_dy;
            w_dd = r_dx;
            w_dl = CMAX;
        end else begin
            w_dn = r_k ? (-r_bh - r_s) : (-r_bh + r_s);
            w_dd = r_a;
            w_dl = LIM;
        end
        w_dgo = i_cmd.go && (i_cmd.op == OP_SLOPE || i_cmd.op == OP_U);
        w_sgo = i_cmd.go && (i_cmd.op == OP_SQRT);
    end

    ppl_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_mgo), .i_a(w_ma), .i_b(w_mb),
        .o_prod(w_prod), .o_neg(w_neg), .o_done(w_mdone)
    );

    ppl_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_dgo), .i_num(w_dn), .i_den(w_dd),
        .i_lim(w_dl), .o_q(w_q), .o_done(w_ddone)
    );

    ppl_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_sgo), .i_d(r_d),
        .o_s(w_s), .o_done(w_sdone)
    );

    // fixed-point product: drop fraction bits, saturate, restore sign
    always_comb begin
        w_sh  = w_prod >> FB;
        w_sat = (|w_sh[PW-1:XW]) || (w_sh[XW-1:0] > LIM);
        w_mag = w_sat ? LIM : w_sh[XW-1:0];
        w_mq  = w_neg ? -t_x'(w_mag) : t_x'(w_mag);
    end

    always_comb begin
        w_done = w_mdone | w_ddone | w_sdone;
        w_free = !r_ov || o_fp.ready;
        w_minx = (r_x1 < r_x2) ? r_x1 : r_x2;
        w_maxx = (r_x1 < r_x2) ? r_x2 : r_x1;
        w_xr   = w_rbx + r_u;
        w_keep = (w_xr > w_minx) && (w_xr < w_maxx);
        w_sel  = (r_n == 2'd2) && !(r_p < r_q);
        w_nx   = t_x'(r_x2) + NUDGE;
        w_ny   = t_x'(r_y2) + NUDGE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rob_x <= '0;
            r_rob_y <= '0;
            r_prv_x <= '0;
            r_prv_y <= '0;
            r_prv_r <= '0;
            r_cho_x <= '0;
            r_cho_y <= '0;
            r_first <= 1'b0;
            r_last  <= 1'b0;
            r_ov    <= 1'b0;
            r_n     <= 2'd0;
            r_k     <= 1'b0;
        end else begin
            if (i_acc) begin
                r_x1    <= t_x'(r_prv_x);
                r_y1    <= t_x'(r_prv_y);
                r_rad   <= r_prv_r;
                r_x2    <= t_x'(i_pt.point_x);
                r_y2    <= t_x'(i_pt.point_y);
                r_prv_x <= i_pt.point_x;
                r_prv_y <= i_pt.point_y;
                r_prv_r <= i_pt.look_radius;
                r_first <= i_pt.first_point;
                r_last  <= i_pt.last_point;
                if (i_pt.first_point) begin
                    r_rob_x <= i_pt.robot_x;
                    r_rob_y <= i_pt.robot_y;
                    r_cho_x <= i_pt.point_x;
                    r_cho_y <= i_pt.point_y;
                end
            end

            if (i_cmd.op == OP_EMIT && w_free) begin
                r_ov <= 1'b1;
            end else if (o_fp.ready) begin
                r_ov <= 1'b0;
            end

            case (i_cmd.op)
                OP_NUDGE: begin
                    // start point is moved off a near-horizontal or near-vertical segment
                    if (f_abs(r_y1 - r_y2) < NUDGE) r_y1 <= w_ny;
                    if (f_abs(r_x1 - r_x2) < NUDGE) r_x1 <= w_nx;
                    r_n <= 2'd0;
                    r_k <= 1'b0;
                end
                OP_DIFF: begin
                    r_dx <= r_x2 - r_x1;
                    r_dy <= r_y2 - r_y1;
                    r_ux <= r_x1 - w_rbx;
                    r_vy <= r_y1 - w_rby;
                end
                OP_SLOPE: if (w_done) r_m   <= w_q;
                OP_C:     if (w_done) r_c   <= f_clamp(r_vy - w_mq);
                OP_A:     if (w_done) r_a   <= f_clamp(ONE + w_mq);
                OP_BH:    if (w_done) r_bh  <= w_mq;
                OP_CC1:   if (w_done) r_tmp <= w_mq;
                OP_CC2:   if (w_done) r_cc  <= f_clamp(r_tmp - w_mq);
                OP_P:     if (w_done) r_p   <= w_prod;
                OP_Q:     if (w_done) r_q   <= w_prod;
                OP_DISC:  r_d <= (r_cc <= t_x'(0)) ? (r_p + r_q) : (r_p - r_q);
                OP_SQRT:  if (w_done) r_s   <= w_s;
                OP_U:     if (w_done) r_u   <= w_q;
                OP_V: begin
                    if (w_done) begin
                        r_rx[r_n[0]] <= w_xr;
                        r_ry[r_n[0]] <= w_rby + f_clamp(r_c + w_mq);
                        r_n          <= r_n + 2'd1;
                    end
                end
                OP_NEXT:  r_k <= 1'b1;
                OP_E0X:   if (w_done) r_d <= w_prod;
                OP_E0Y:   if (w_done) r_p <= r_d + w_prod;
                OP_E1X:   if (w_done) r_d <= w_prod;
                OP_E1Y:   if (w_done) r_q <= r_d + w_prod;
                OP_PICK: begin
                    // with two roots the one nearer the segment end wins, ties to the second
                    if (r_n != 2'd0) begin
                        r_cho_x <= f_coord(w_sel ? r_rx[1] : r_rx[0]);
                        r_cho_y <= f_coord(w_sel ? r_ry[1] : r_ry[0]);
                    end
                end
                OP_EMIT: begin
                    if (w_free) begin
                        r_ofx <= r_cho_x;
                        r_ofy <= r_cho_y;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sts.done     = w_done;
        o_sts.first    = r_first;
        o_sts.last     = r_last;
        o_sts.no_root  = (r_cc > t_x'(0)) && (r_p < r_q);
        o_sts.keep     = w_keep;
        o_sts.k        = r_k;
        o_sts.two      = (r_n == 2'd2);
        o_sts.out_free = w_free;
    end

    assign o_fp.valid    = r_ov;
    assign o_fp.follow_x = r_ofx;
    assign o_fp.follow_y = r_ofy;

endmodule

@@ sv/ppl_ctrl.sv @@
// Controller: sequences one segment through the datapath's shared units.
module ppl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  ppl_pkg::t_sts  i_sts,
    output ppl_pkg::t_cmd  o_cmd,
    output logic           o_ready
);
    import ppl_pkg::*;

    typedef enum logic [23:0] {
        S_IDLE   = 24'h000001,
        S_BRANCH = 24'h000002,
        S_NUDGE  = 24'h000004,
        S_DIFF   = 24'h000008,
        S_SLOPE  = 24'h000010,
        S_MC     = 24'h000020,
        S_MA     = 24'h000040,
        S_MBH    = 24'h000080,
        S_MCC1   = 24'h000100,
        S_MCC2   = 24'h000200,
        S_MP     = 24'h000400,
        S_MQ     = 24'h000800,
        S_DISC   = 24'h001000,
        S_SQRT   = 24'h002000,
        S_DU     = 24'h004000,
        S_XR     = 24'h008000,
        S_MV     = 24'h010000,
        S_NEXT   = 24'h020000,
        S_E0X    = 24'h040000,
        S_E0Y    = 24'h080000,
        S_E1X    = 24'h100000,
        S_E1Y    = 24'h200000,
        S_PICK   = 24'h400000,
        S_EMIT   = 24'h800000
    } t_state;

    t_state r_state, n_state, w_fin, w_after;
    logic   r_issued, n_issued, w_unit;
    t_op    w_op;

    always_comb begin
        w_fin   = i_sts.last ? S_EMIT : S_IDLE;
        n_state = r_state;
        w_op    = OP_NONE;
        w_unit  = 1'b0;
        w_after = r_state;
        case (r_state)
            S_IDLE:   if (i_acc) n_state = S_BRANCH;
            S_BRANCH: n_state = i_sts.first ? w_fin : S_NUDGE;
            S_NUDGE:  begin w_op = OP_NUDGE; n_state = S_DIFF; end
            S_DIFF:   begin w_op = OP_DIFF;  n_state = S_SLOPE; end
            S_SLOPE:  begin w_op = OP_SLOPE; w_unit = 1'b1; w_after = S_MC;   end
            S_MC:     begin w_op = OP_C;     w_unit = 1'b1; w_after = S_MA;   end
            S_MA:     begin w_op = OP_A;     w_unit = 1'b1; w_after = S_MBH;  end
            S_MBH:    begin w_op = OP_BH;    w_unit = 1'b1; w_after = S_MCC1; end
            S_MCC1:   begin w_op = OP_CC1;   w_unit = 1'b1; w_after = S_MCC2; end
            S_MCC2:   begin w_op = OP_CC2;   w_unit = 1'b1; w_after = S_MP;   end
            S_MP:     begin w_op = OP_P;     w_unit = 1'b1; w_after = S_MQ;   end
            S_MQ:     begin w_op = OP_Q;     w_unit = 1'b1; w_after = S_DISC; end
            S_DISC: begin
                w_op    = OP_DISC;
                n_state = i_sts.no_root ? w_fin : S_SQRT;
            end
            S_SQRT:   begin w_op = OP_SQRT;  w_unit = 1'b1; w_after = S_DU;   end
            S_DU:     begin w_op = OP_U;     w_unit = 1'b1; w_after = S_XR;   end
            S_XR:     n_state = i_sts.keep ? S_MV : S_NEXT;
            S_MV:     begin w_op = OP_V;     w_unit = 1'b1; w_after = S_NEXT; end
            S_NEXT: begin
                // second pass takes the minus root
                w_op = OP_NEXT;
                if (!i_sts.k) n_state = S_DU;
                else          n_state = i_sts.two ? S_E0X : S_PICK;
            end
            S_E0X:    begin w_op = OP_E0X;   w_unit = 1'b1; w_after = S_E0Y;  end
            S_E0Y:    begin w_op = OP_E0Y;   w_unit = 1'b1; w_after = S_E1X;  end
            S_E1X:    begin w_op = OP_E1X;   w_unit = 1'b1; w_after = S_E1Y;  end
            S_E1Y:    begin w_op = OP_E1Y;   w_unit = 1'b1; w_after = S_PICK; end
            S_PICK:   begin w_op = OP_PICK;  n_state = w_fin; end
            S_EMIT: begin
                w_op = OP_EMIT;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
        if (w_unit && i_sts.done) n_state = w_after;
    end

    always_comb begin
        o_cmd.op = w_op;
        o_cmd.go = w_unit && !r_issued;
        if (i_sts.done)    n_issued = 1'b0;
        else if (o_cmd.go) n_issued = 1'b1;
        else               n_issued = r_issued;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ sv/pure_pursuit_lookahead_point.sv @@
// Pure pursuit lookahead point: takes path point items one at a time and, on the
// item marked last, delivers the chosen follow point (Q16.16). One item is in work
// at a time. A first-point item skips the segment arithmetic. A segment item ends
// early when the discriminant is negative and runs longest when both roots are
// tested and kept; an item marked last also passes through the emit step, which
// waits while the output register is still full. Segment time is set by the shared
// one-bit-per-cycle divider (used for the slope and for each root), the digit-by-digit
// square root and the 4-partial-product multiplier. The output register holds a
// follow point until taken.
module pure_pursuit_lookahead_point (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppl_in_if.sink     i_pt,
    ppl_out_if.source  o_fp
);
    import ppl_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready, w_acc;

    assign i_pt.ready = w_ready;
    assign w_acc      = i_pt.valid && w_ready;

    ppl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(w_acc), .i_sts(w_sts),
        .o_cmd(w_cmd), .o_ready(w_ready)
    );

    ppl_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(w_acc), .i_cmd(w_cmd),
        .o_sts(w_sts), .i_pt(i_pt), .o_fp(o_fp)
    );

endmodule

@@ sv/ppl_chk.sv @@
// Port-level checks of the lookahead point block, bound to its top level.
module ppl_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [ppl_pkg::CW-1:0] i_follow_x,
    input logic signed [ppl_pkg::CW-1:0] i_follow_y
);
    import ppl_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second item taken while one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("follow point dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_follow_x) && $stable(i_follow_y)))
        else $error("stalled follow point changed");

endmodule

bind pure_pursuit_lookahead_point ppl_chk u_ppl_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_pt.valid),
    .i_in_ready(i_pt.ready),
    .i_out_valid(o_fp.valid),
    .i_out_ready(o_fp.ready),
    .i_follow_x(o_fp.follow_x),
    .i_follow_y(o_fp.follow_y)
);

@@ verif/ppl_checker.sv @@
// Follow point predictor and checker watching both channels of the lookahead block.
`timescale 1ns / 1ps

module ppl_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ppl_in_if     i_pt,
    ppl_out_if    i_fp,
    output int    o_errors,
    output int    o_pending
);

    localparam int     FRAC       = ppl_pkg::FB;
    localparam longint SAT_Q      = longint'((64'd1 << 61) - 64'd1);
    localparam longint ONE_Q      = longint'(64'd1 << FRAC);
    localparam longint NUDGE_STEP = ((3 << FRAC) + 500) / 1000;
    localparam longint COORD_MAX  = longint'((64'd1 << (ppl_pkg::CW - 1)) - 64'd1);
    localparam longint COORD_MIN  = -COORD_MAX - 1;

    typedef struct {
        logic signed [ppl_pkg::CW-1:0] x;
        logic signed [ppl_pkg::CW-1:0] y;
    } follow_t;

    follow_t expected_follow[$];

    longint robot_x_q, robot_y_q, last_x, last_y, last_radius, follow_x_q, follow_y_q;

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [127:0] wide_mul(input logic [63:0] a, input logic [63:0] b);
        return {64'd0, a} * {64'd0, b};
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        logic [127:0] p;
        logic [63:0]  r;
        p = wide_mul(mag(a), mag(b)) >> FRAC;
        r = (p > 128'(SAT_Q)) ? 64'(SAT_Q) : p[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint q_div(input longint num, input longint den, input longint lim);
        logic [127:0] q;
        logic [63:0]  r;
        if (den == 0)
            return num < 0 ? -lim : lim;
        q = ({64'd0, mag(num)} << FRAC) / {64'd0, mag(den)};
        r = (q > 128'(lim)) ? 64'(lim) : q[63:0];
        return ((num < 0) != (den < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint floor_sqrt(input logic [127:0] d);
        logic [63:0] s;
        logic [63:0] c;
        s = 0;
        for (int b = 62; b >= 0; b--) begin
            c = s | (64'd1 << b);
            if (!(d < wide_mul(c, c)))
                s = c;
        end
        return longint'(s);
    endfunction

    function automatic logic [127:0] dist_sq(input longint ex, input longint ey);
        return wide_mul(mag(ex), mag(ex)) + wide_mul(mag(ey), mag(ey));
    endfunction

    // Intersect one segment with the lookahead circle; may move the follow point.
    task automatic intersect_segment(input longint x1, input longint y1, input longint x2,
                                     input longint y2, input longint rad);
        longint dx, dy, m, lo_x, hi_x, c, a, bh, cc, s, num, u, xr;
        longint rx[2], ry[2];
        logic [127:0] p, q, d;
        int n, k;
        n = 0;
        if (mag(y1 - y2) < 64'(NUDGE_STEP)) y1 = y2 + NUDGE_STEP;
        if (mag(x1 - x2) < 64'(NUDGE_STEP)) x1 = x2 + NUDGE_STEP;
        dx = x2 - x1;
        dy = y2 - y1;
        m = q_div(dy, dx, COORD_MAX);
        lo_x = x1 < x2 ? x1 : x2;
        hi_x = x1 < x2 ? x2 : x1;
        c  = clip((y1 - robot_y_q) - q_mul(m, x1 - robot_x_q), -SAT_Q, SAT_Q);
        a  = clip(ONE_Q + q_mul(m, m), -SAT_Q, SAT_Q);
        bh = q_mul(m, c);
        cc = clip(q_mul(c, c) - q_mul(rad, rad), -SAT_Q, SAT_Q);
        p = wide_mul(mag(bh), mag(bh));
        if (cc <= 0) begin
            d = p + wide_mul(64'(a), mag(cc));
        end else begin
            q = wide_mul(64'(a), 64'(cc));
            if (p < q)
                return;
            d = p - q;
        end
        s = floor_sqrt(d);
        for (k = 0; k < 2; k++) begin
            num = (k == 0) ? -bh + s : -bh - s;
            u = q_div(num, a, SAT_Q);
            xr = robot_x_q + u;
            if (xr > lo_x && xr < hi_x) begin
                rx[n] = xr;
                ry[n] = robot_y_q + clip(c + q_mul(m, u), -SAT_Q, SAT_Q);
                n++;
            end
        end
        if (n == 0)
            return;
        k = 0;
        if (n == 2 && !(dist_sq(x2 - rx[0], y2 - ry[0]) < dist_sq(x2 - rx[1], y2 - ry[1])))
            k = 1;
        follow_x_q = clip(rx[k], COORD_MIN, COORD_MAX);
        follow_y_q = clip(ry[k], COORD_MIN, COORD_MAX);
    endtask

    assign o_pending = expected_follow.size();

    always @(posedge i_clk) begin
        longint px, py;
        follow_t got, exp_f;
        if (!i_rst_n) begin
            robot_x_q = 0; robot_y_q = 0; last_x = 0; last_y = 0;
            last_radius = 0; follow_x_q = 0; follow_y_q = 0;
            expected_follow.delete();
            o_errors = 0;
        end else begin
            if (i_pt.valid && i_pt.ready) begin
                px = longint'(i_pt.point_x);
                py = longint'(i_pt.point_y);
                if (i_pt.first_point) begin
                    robot_x_q = longint'(i_pt.robot_x);
                    robot_y_q = longint'(i_pt.robot_y);
                    follow_x_q = px;
                    follow_y_q = py;
                end else begin
                    intersect_segment(last_x, last_y, px, py, last_radius);
                end
                last_x = px;
                last_y = py;
                last_radius = longint'({1'b0, i_pt.look_radius});
                if (i_pt.last_point) begin
                    exp_f.x = follow_x_q[ppl_pkg::CW-1:0];
                    exp_f.y = follow_y_q[ppl_pkg::CW-1:0];
                    expected_follow = {expected_follow, exp_f};
                end
            end
            if (i_fp.valid && i_fp.ready) begin
                got.x = i_fp.follow_x;
                got.y = i_fp.follow_y;
                if (expected_follow.size() == 0) begin
                    $display("%0t: unexpected follow point x=%h y=%h", $time, got.x, got.y);
                    o_errors++;
                end else begin
                    exp_f = expected_follow.pop_front();
                    if (got.x !== exp_f.x) begin
                        $display("%0t: follow_x expected %h got %h", $time, exp_f.x, got.x);
                        o_errors++;
                    end
                    if (got.y !== exp_f.y) begin
                        $display("%0t: follow_y expected %h got %h", $time, exp_f.y, got.y);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

@@ verif/tb_pure_pursuit_lookahead_point.sv @@
// Testbench top: drives path point items, stalls the follow point side, reports the verdict.
`timescale 1ns / 1ps

module tb_pure_pursuit_lookahead_point;

    localparam int     TARGET_ITEMS = 600;
    localparam int     CYCLE_LIMIT  = 3000000;
    localparam longint UNIT         = 64'd1 << ppl_pkg::FB;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles;
    int   sent;
    int   burst_left;
    bit   hold_req;
    int   hold_left;
    int   stall_phase;

    ppl_in_if  pt_ch();
    ppl_out_if fp_ch();

    pure_pursuit_lookahead_point i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch.sink),
        .o_fp    (fp_ch.source)
    );

    ppl_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pt      (pt_ch),
        .i_fp      (fp_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: rotating stall patterns plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            fp_ch.ready = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            fp_ch.ready = 0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = 3000;
            fp_ch.ready = 0;
        end else begin
            stall_phase = (cycles / 700) % 3;
            case (stall_phase)
                0: fp_ch.ready = 1;
                1: fp_ch.ready = $urandom_range(0, 1);
                default: fp_ch.ready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic logic signed [31:0] near_coord(input int span);
        return 32'(longint'($urandom_range(0, 2 * span * 65536)) - longint'(span) * UNIT);
    endfunction

    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic [30:0] rad, input logic signed [31:0] rx,
                              input logic signed [31:0] ry, input bit first, input bit last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                pt_ch.valid = 0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        pt_ch.valid = 1;
        pt_ch.point_x = x;
        pt_ch.point_y = y;
        pt_ch.look_radius = rad;
        pt_ch.robot_x = rx;
        pt_ch.robot_y = ry;
        pt_ch.first_point = first;
        pt_ch.last_point = last;
        do @(posedge i_clk); while (!pt_ch.ready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain_results;
        pt_ch.valid = 0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic send_path(input int span);
        logic signed [31:0] rx, ry;
        int mids;
        rx = near_coord(span);
        ry = near_coord(span);
        mids = $urandom_range(0, 5);
        send_point(near_coord(span), near_coord(span), 31'($urandom_range(1, span * 65536)),
                   rx, ry, 1, 0);
        repeat (mids)
            send_point(near_coord(span), near_coord(span),
                       31'($urandom_range(1, span * 65536)), $urandom, $urandom, 0, 0);
        send_point(near_coord(span), near_coord(span), 31'($urandom), $urandom, $urandom, 0, 1);
    endtask

    initial begin
        cycles = 0; sent = 0; burst_left = 0; hold_req = 0; hold_left = 0;
        i_rst_n = 0;
        pt_ch.valid = 0; pt_ch.point_x = 0; pt_ch.point_y = 0; pt_ch.look_radius = 0;
        pt_ch.robot_x = 0; pt_ch.robot_y = 0; pt_ch.first_point = 0; pt_ch.last_point = 0;
        fp_ch.ready = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // segment off the zero state before any first point
        send_point(32'sd3 << 16, -(32'sd2 << 16), 31'd5 << 16, 0, 0, 0, 1);
        // first and last together, extremes
        send_point(32'h7fffffff, 32'h80000000, 31'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 1);
        send_point(32'h80000000, 32'h7fffffff, 31'd0, 32'h7fffffff, 32'h80000000, 1, 1);
        // horizontal segment: y nudge, two roots
        send_point(-(32'sd5 << 16), 0, 31'd3 << 16, 0, 0, 1, 0);
        send_point(32'sd5 << 16, 0, 31'd1 << 16, 0, 0, 0, 1);
        // vertical segment: x nudge, steep slope
        send_point(32'sd1 << 16, -(32'sd10 << 16), 31'd4 << 16, 0, 0, 1, 0);
        send_point(32'sd1 << 16, 32'sd10 << 16, 31'd4 << 16, 0, 0, 0, 1);
        // repeated point: both nudges
        send_point(32'sd2 << 16, 32'sd2 << 16, 31'd1 << 16, 32'sd2 << 16, 32'sd2 << 16, 1, 0);
        send_point(32'sd2 << 16, 32'sd2 << 16, 31'd1 << 16, 0, 0, 0, 1);
        // circle misses the line: negative discriminant
        send_point(-(32'sd5 << 16), 32'sd10 << 16, 31'd2 << 16, 0, 0, 1, 0);
        send_point(32'sd5 << 16, 32'sd10 << 16, 31'd2 << 16, 0, 0, 0, 1);
        // extremes of coordinates with maximum radius
        send_point(32'h80000000, 32'h80000000, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0);
        send_point(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 0, 0, 0, 0);
        send_point(32'h80000000, 32'h7fffffff, 31'h7fffffff, 0, 0, 0, 1);
        // restart: a second first point re-latches the robot
        send_point(32'sd1 << 16, 32'sd1 << 16, 31'd8 << 16, 32'sd9 << 16, 32'sd9 << 16, 1, 0);
        send_point(-(32'sd4 << 16), 32'sd3 << 16, 31'd6 << 16, 0, 0, 1, 0);
        send_point(32'sd6 << 16, -(32'sd2 << 16), 31'd6 << 16, 0, 0, 0, 0);
        send_point(32'sd7 << 16, 32'sd9 << 16, 31'd6 << 16, 0, 0, 0, 1);

        // sender pauses until every follow point is back
        drain_results();

        while (sent < TARGET_ITEMS) begin
            if (sent > 200 && sent < 210 && hold_left == 0)
                hold_req = 1;
            case ($urandom_range(0, 9))
                0: send_point($urandom, $urandom, 31'($urandom), $urandom, $urandom,
                              $urandom_range(0, 1), $urandom_range(0, 1));
                1: send_path(30000);
                2, 3: send_path(10);
                default: send_path(100);
            endcase
        end

        drain_results();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
